[sv/cspwq_pkg.sv]
// ----------------------------------------------------------------------------
// cspwq_pkg: shared types and constants of the counting semaphore
// Function and status codes, register indexes, and the cell-chain structs.
// ----------------------------------------------------------------------------
package cspwq_pkg;

   // wait list depth and derived widths
   localparam int MAX_TASKS = 16;
   localparam int TOTAL_W   = $clog2(MAX_TASKS + 1);

   // field widths
   localparam int ID_W     = 4;
   localparam int PRIO_W   = 8;
   localparam int COUNT_W  = 16;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 3;

   // configuration port
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] REG_INITIAL_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_COUNT_LIMIT   = CSR_IDX_W'(1);

   // stream word widths
   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = FUNC_W;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = STATUS_W + 1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TAKE   = 2'd0,
      FUNC_GIVE   = 2'd1,
      FUNC_CANCEL = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_BLOCKED  = 3'd1,
      ST_TIMEOUT  = 3'd2,
      ST_OVERFLOW = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   // command broadcast to every cell
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_POP    = 2'd2,
      OP_REMOVE = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } cell_cmd_type;

   // what one cell hands to its neighbors
   typedef struct packed {
      logic              stay;   // entry is ahead of the new task
      logic              found;  // a matching id sits here or earlier
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } cell_link_type;

endpackage

[sv/cspwq_cell.sv]
// ----------------------------------------------------------------------------
// cspwq_cell: one slot of the sorted wait list
// Holds one waiter id and priority; shifts toward tail on insert and
// toward head on pop or remove, taking data from the matching neighbor.
// ----------------------------------------------------------------------------
module cspwq_cell (
   input  logic                     clock,
   input  cspwq_pkg::cell_cmd_type  cmd,
   input  logic                     occupied,
   input  cspwq_pkg::cell_link_type left_link,
   input  cspwq_pkg::cell_link_type right_link,
   output cspwq_pkg::cell_link_type link
);

   logic [cspwq_pkg::ID_W-1:0]   id_ff, id_in;
   logic [cspwq_pkg::PRIO_W-1:0] prio_ff, prio_in;
   logic                         stay;
   logic                         match;

   // equal priority stays ahead, so arrival order is kept
   assign stay  = occupied && (prio_ff <= cmd.prio);
   assign match = occupied && (id_ff == cmd.id);

   assign link.stay  = stay;
   assign link.found = left_link.found | match;
   assign link.id    = id_ff;
   assign link.prio  = prio_ff;

   // next slot contents
   always_comb begin
      id_in   = id_ff;
      prio_in = prio_ff;
      case (cmd.op)
         cspwq_pkg::OP_INSERT: begin
            if (!stay) begin
               if (left_link.stay) begin
                  id_in   = cmd.id;
                  prio_in = cmd.prio;
               end else begin
                  id_in   = left_link.id;
                  prio_in = left_link.prio;
               end
            end
         end
         cspwq_pkg::OP_POP: begin
            id_in   = right_link.id;
            prio_in = right_link.prio;
         end
         cspwq_pkg::OP_REMOVE: begin
            if (left_link.found || match) begin
               id_in   = right_link.id;
               prio_in = right_link.prio;
            end
         end
         default: begin
         end
      endcase
   end

   // slot payload, no reset
   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      prio_ff <= prio_in;
   end

endmodule

[sv/counting_semaphore_priority_waitq_unit.sv]
// Response: an accepted request word has its response registered and shown in the cycle after.
// Throughput: one request per cycle unless a response stalls; all cells shift together.
// The cancel search ripples a found flag through the MAX_TASKS cells.
// Reset: count 0, initial_count 0, count limit 1, wait list empty; list slots are not cleared.
// ----------------------------------------------------------------------------
// counting_semaphore_priority_waitq_unit: counting semaphore with wait list
// Keeps the count and a priority-sorted chain of waiting tasks; take, give
// and cancel requests each return one response word.
// ----------------------------------------------------------------------------
module counting_semaphore_priority_waitq_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: task_id[3:0], task_priority[11:4], may_wait[12], zero fill
   input  logic [cspwq_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: func[1:0]
   input  logic [cspwq_pkg::REQ_USER_W-1:0]    req_tuser,
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: woken_task[3:0], count_now[19:4], zero fill
   output logic [cspwq_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // tuser: status[2:0], woken_valid[3]
   output logic [cspwq_pkg::RSP_USER_W-1:0]    rsp_tuser,
   // configuration write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cspwq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cspwq_pkg::COUNT_W-1:0]       csr_data
);

   localparam int N = cspwq_pkg::MAX_TASKS;

   // request fields
   cspwq_pkg::func_type                func;
   logic [cspwq_pkg::ID_W-1:0]         req_id;
   logic [cspwq_pkg::PRIO_W-1:0]       req_prio;
   logic                               req_may_wait;
   logic                               accept;

   assign func         = cspwq_pkg::func_type'(req_tuser[cspwq_pkg::FUNC_W-1:0]);
   assign req_id       = req_tdata[3:0];
   assign req_prio     = req_tdata[11:4];
   assign req_may_wait = req_tdata[12];

   // state
   logic [cspwq_pkg::COUNT_W-1:0]  init_ff, init_in;
   logic [cspwq_pkg::COUNT_W-1:0]  max_ff, max_in;
   logic [cspwq_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [cspwq_pkg::TOTAL_W-1:0]  total_ff, total_in;

   // response register
   logic                           rsp_valid_ff, rsp_valid_in;
   cspwq_pkg::status_type          status_ff, status_in;
   logic                           woken_valid_ff, woken_valid_in;
   logic [cspwq_pkg::ID_W-1:0]     woken_task_ff, woken_task_in;
   logic [cspwq_pkg::COUNT_W-1:0]  count_out_ff;

   // cell chain
   cspwq_pkg::cell_cmd_type        cmd;
   cspwq_pkg::cell_link_type       links [N];
   cspwq_pkg::cell_link_type       head_link;
   cspwq_pkg::cell_link_type       tail_link;
   logic [N-1:0]                   occupied;
   logic                           list_full;
   logic                           list_empty;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // head takes the new task when it is not ahead; nothing found before it
   assign head_link = '{stay: 1'b1, found: 1'b0, id: '0, prio: '0};
   assign tail_link = '{stay: 1'b0, found: 1'b0, id: '0, prio: '0};

   assign list_full  = (total_ff == cspwq_pkg::TOTAL_W'(N));
   assign list_empty = (total_ff == '0);

   genvar k;
   generate
      for (k = 0; k < N; k++) begin : g_cell
         cspwq_pkg::cell_link_type left_l;
         cspwq_pkg::cell_link_type right_l;

         assign occupied[k] = (cspwq_pkg::TOTAL_W'(k) < total_ff);

         if (k == 0) begin : g_head
            assign left_l = head_link;
         end else begin : g_left
            assign left_l = links[k-1];
         end
         if (k == N - 1) begin : g_tail
            assign right_l = tail_link;
         end else begin : g_right
            assign right_l = links[k+1];
         end

         cspwq_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .occupied   (occupied[k]),
            .left_link  (left_l),
            .right_link (right_l),
            .link       (links[k])
         );
      end
   endgenerate

   // request decode
   always_comb begin
      cmd.op         = cspwq_pkg::OP_HOLD;
      cmd.id         = req_id;
      cmd.prio       = req_prio;
      count_in       = count_ff;
      total_in       = total_ff;
      status_in      = cspwq_pkg::ST_OK;
      woken_valid_in = 1'b0;
      woken_task_in  = '0;
      case (func)
         cspwq_pkg::FUNC_TAKE: begin
            if (count_ff != '0) begin
               count_in = count_ff - 1'b1;
            end else if (!req_may_wait) begin
               status_in = cspwq_pkg::ST_TIMEOUT;
            end else if (list_full) begin
               status_in = cspwq_pkg::ST_FULL;
            end else begin
               cmd.op    = cspwq_pkg::OP_INSERT;
               total_in  = total_ff + 1'b1;
               status_in = cspwq_pkg::ST_BLOCKED;
            end
         end
         cspwq_pkg::FUNC_GIVE: begin
            if (!list_empty) begin
               cmd.op         = cspwq_pkg::OP_POP;
               total_in       = total_ff - 1'b1;
               woken_valid_in = 1'b1;
               woken_task_in  = links[0].id;
            end else if (count_ff < max_ff) begin
               count_in = count_ff + 1'b1;
            end else begin
               status_in = cspwq_pkg::ST_OVERFLOW;
            end
         end
         cspwq_pkg::FUNC_CANCEL: begin
            status_in = cspwq_pkg::ST_TIMEOUT;
            cmd.op    = cspwq_pkg::OP_REMOVE;
            if (links[N-1].found) begin
               total_in = total_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (!accept) begin
         cmd.op = cspwq_pkg::OP_HOLD;
      end
   end

   // configuration values; a zero count limit reads as one
   always_comb begin
      init_in = init_ff;
      max_in  = max_ff;
      if (csr_valid) begin
         case (csr_index)
            cspwq_pkg::REG_INITIAL_COUNT: init_in = csr_data;
            cspwq_pkg::REG_COUNT_LIMIT: max_in = (csr_data == '0) ?
                                                 cspwq_pkg::COUNT_W'(1) : csr_data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && !rsp_tready);

   // semaphore state
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff  <= '0;
         max_ff   <= cspwq_pkg::COUNT_W'(1);
         count_ff <= '0;
         total_ff <= '0;
      end else if (csr_valid && ((csr_index == cspwq_pkg::REG_INITIAL_COUNT) ||
                                 (csr_index == cspwq_pkg::REG_COUNT_LIMIT))) begin
         init_ff  <= init_in;
         max_ff   <= max_in;
         count_ff <= (init_in > max_in) ? max_in : init_in;
      end else if (accept) begin
         count_ff <= count_in;
         total_ff <= total_in;
      end
   end

   // response word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff      <= status_in;
         woken_valid_ff <= woken_valid_in;
         woken_task_ff  <= woken_task_in;
         count_out_ff   <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, count_out_ff, woken_task_ff};
   assign rsp_tuser  = {woken_valid_ff, status_ff};

`ifndef SYNTHESIS
   // list fill never passes the chain length
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= cspwq_pkg::TOTAL_W'(N))
      else $error("wait list fill beyond chain length");

   // count always clamped to the limit
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= max_ff)
      else $error("count above count limit");

   // a woken task only comes with an ok status
   a_woken_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && woken_valid_ff) |-> (status_ff == cspwq_pkg::ST_OK))
      else $error("woken task with non-ok status");

   // a blocked take grows the list by one
   a_block_grow: assert property (@(posedge clock) disable iff (reset)
      (accept && (status_in == cspwq_pkg::ST_BLOCKED) && !csr_valid)
      |=> (total_ff == $past(total_ff) + 1'b1))
      else $error("blocked take did not enqueue");

   // the head waiter's priority value is no greater than that of the second waiter
   a_head_order: assert property (@(posedge clock) disable iff (reset)
      (total_ff > cspwq_pkg::TOTAL_W'(1)) |-> (links[0].prio <= links[1].prio))
      else $error("wait list head out of order");
`endif

endmodule

[verif/counting_semaphore_priority_waitq_unit_test.sv]
// ----------------------------------------------------------------------------
// counting_semaphore_priority_waitq_unit_test: self-checking bench for the semaphore
// Drives take, give and cancel words and register writes from a queue of
// pending calls. A clocked monitor predicts each response from its own copy
// of the count and the priority-sorted wait list, then checks every response
// word field by field. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module counting_semaphore_priority_waitq_unit_test;

   localparam int TOTAL_CALLS  = 640;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE       = 2;
   localparam int TAIL_CYCLES  = 8;
   localparam int CYCLE_LIMIT  = 600000;

   typedef enum logic [1:0] {
      CALL_REQ   = 2'd0,
      CALL_REG   = 2'd1,
      CALL_DRAIN = 2'd2,
      CALL_HOLD  = 2'd3
   } call_kind_type;

   typedef struct packed {
      call_kind_type                    kind;
      cspwq_pkg::func_type              func;
      logic [cspwq_pkg::ID_W-1:0]       id;
      logic [cspwq_pkg::PRIO_W-1:0]     prio;
      logic                             may_wait;
      logic [cspwq_pkg::CSR_IDX_W-1:0]  reg_index;
      logic [cspwq_pkg::COUNT_W-1:0]    reg_value;
   } kernel_call_type;

   typedef struct packed {
      cspwq_pkg::status_type            status;
      logic                             woken_valid;
      logic [cspwq_pkg::ID_W-1:0]       woken_task;
      logic [cspwq_pkg::COUNT_W-1:0]    count_now;
   } sem_result_type;

   // block ports
   logic                               clock      = 1'b0;
   logic                               reset      = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [cspwq_pkg::REQ_DATA_W-1:0]   req_tdata  = '0;
   logic [cspwq_pkg::REQ_USER_W-1:0]   req_tuser  = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [cspwq_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic [cspwq_pkg::RSP_USER_W-1:0]   rsp_tuser;
   logic                               csr_valid  = 1'b0;
   logic                               csr_ready;
   logic [cspwq_pkg::CSR_IDX_W-1:0]    csr_index  = '0;
   logic [cspwq_pkg::COUNT_W-1:0]      csr_data   = '0;

   // stimulus and checking state
   kernel_call_type         call_queue[$];
   sem_result_type          results_due[$];
   int                      calls_left     = 1;
   int                      outstanding    = 0;
   int                      mismatch_count = 0;
   int                      cycle_count    = 0;
   int                      tx_gap         = 0;
   int                      tx_quiet       = 0;
   int                      rx_gap         = 0;
   int                      rx_hold        = 0;
   logic                    rx_hold_go     = 1'b0;
   logic                    calm_stretch;

   // predicted semaphore state
   logic [cspwq_pkg::COUNT_W-1:0]  cfg_initial   = '0;
   logic [cspwq_pkg::COUNT_W-1:0]  cfg_max       = cspwq_pkg::COUNT_W'(1);
   logic [cspwq_pkg::COUNT_W-1:0]  sem_level     = '0;
   logic [cspwq_pkg::ID_W-1:0]     waiter_id[cspwq_pkg::MAX_TASKS];
   logic [cspwq_pkg::PRIO_W-1:0]   waiter_prio[cspwq_pkg::MAX_TASKS];
   int                             waiter_count  = 0;

   counting_semaphore_priority_waitq_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // calm stretches, one in every four, add no random gaps on either side
   assign calm_stretch = ((cycle_count / 512) % 4) == 3;

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(25, 80);
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------
   task automatic reload_level();
      sem_level = (cfg_initial > cfg_max) ? cfg_max : cfg_initial;
   endtask

   task automatic semaphore_config(input logic [cspwq_pkg::CSR_IDX_W-1:0] idx,
                                   input logic [cspwq_pkg::COUNT_W-1:0] value);
      if (idx == cspwq_pkg::REG_INITIAL_COUNT) begin
         cfg_initial = value;
         reload_level();
      end else if (idx == cspwq_pkg::REG_COUNT_LIMIT) begin
         cfg_max = (value == '0) ? cspwq_pkg::COUNT_W'(1) : value;
         reload_level();
      end
   endtask

   task automatic remove_waiter(input int pos);
      for (int k = pos; k + 1 < waiter_count; k++) begin
         waiter_id[k]   = waiter_id[k + 1];
         waiter_prio[k] = waiter_prio[k + 1];
      end
      waiter_count--;
   endtask

   task automatic semaphore_step(input cspwq_pkg::func_type f,
                                 input logic [cspwq_pkg::ID_W-1:0] id,
                                 input logic [cspwq_pkg::PRIO_W-1:0] prio,
                                 input logic may_wait,
                                 output sem_result_type r);
      int pos;
      r.status      = cspwq_pkg::ST_OK;
      r.woken_valid = 1'b0;
      r.woken_task  = '0;
      case (f)
         cspwq_pkg::FUNC_TAKE: begin
            if (sem_level != '0) begin
               sem_level = sem_level - 1'b1;
            end else if (!may_wait) begin
               r.status = cspwq_pkg::ST_TIMEOUT;
            end else if (waiter_count >= cspwq_pkg::MAX_TASKS) begin
               r.status = cspwq_pkg::ST_FULL;
            end else begin
               // equal priorities stay behind earlier arrivals
               pos = 0;
               while (pos < waiter_count && waiter_prio[pos] <= prio) pos++;
               for (int k = waiter_count; k > pos; k--) begin
                  waiter_id[k]   = waiter_id[k - 1];
                  waiter_prio[k] = waiter_prio[k - 1];
               end
               waiter_id[pos]   = id;
               waiter_prio[pos] = prio;
               waiter_count++;
               r.status = cspwq_pkg::ST_BLOCKED;
            end
         end
         cspwq_pkg::FUNC_GIVE: begin
            if (waiter_count > 0) begin
               r.woken_valid = 1'b1;
               r.woken_task  = waiter_id[0];
               remove_waiter(0);
            end else if (sem_level < cfg_max) begin
               sem_level = sem_level + 1'b1;
            end else begin
               r.status = cspwq_pkg::ST_OVERFLOW;
            end
         end
         cspwq_pkg::FUNC_CANCEL: begin
            // first match from the head; no match still reports timeout
            r.status = cspwq_pkg::ST_TIMEOUT;
            pos = -1;
            for (int k = 0; k < waiter_count; k++) begin
               if (pos < 0 && waiter_id[k] == id) pos = k;
            end
            if (pos >= 0) remove_waiter(pos);
         end
         default: ;
      endcase
      r.count_now = sem_level;
   endtask

   // ---------------------------------------------------------------------
   // driver: serves both the request stream and the register channel
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_calls
      logic            nv_req;
      logic            nv_csr;
      logic            nv_hold;
      int              quiet;
      kernel_call_type c;
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_valid  <= 1'b0;
         rx_hold_go <= 1'b0;
         tx_gap     <= 0;
         tx_quiet   <= 0;
         calls_left <= call_queue.size();
      end else begin
         nv_req  = req_tvalid && !req_tready;
         nv_csr  = csr_valid && !csr_ready;
         nv_hold = 1'b0;
         quiet   = (outstanding == 0 && !req_tvalid && !csr_valid) ? tx_quiet + 1 : 0;
         if (!nv_req && !nv_csr) begin
            if (tx_gap > 0) begin
               tx_gap <= tx_gap - 1;
            end else if (call_queue.size() > 0) begin
               c = call_queue[0];
               case (c.kind)
                  CALL_REQ: begin
                     void'(call_queue.pop_front());
                     nv_req = 1'b1;
                     req_tdata <= cspwq_pkg::REQ_DATA_W'({c.may_wait, c.prio, c.id});
                     req_tuser <= c.func;
                     tx_gap <= (calm_stretch || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
                  end
                  CALL_REG: begin
                     // registers change only with nothing in flight
                     if (quiet >= SETTLE) begin
                        void'(call_queue.pop_front());
                        nv_csr = 1'b1;
                        csr_index <= c.reg_index;
                        csr_data  <= c.reg_value;
                     end
                  end
                  CALL_DRAIN: begin
                     if (quiet >= SETTLE) void'(call_queue.pop_front());
                  end
                  default: begin
                     void'(call_queue.pop_front());
                     nv_hold = 1'b1;
                  end
               endcase
            end
         end
         req_tvalid <= nv_req;
         csr_valid  <= nv_csr;
         rx_hold_go <= nv_hold;
         tx_quiet   <= quiet;
         calls_left <= call_queue.size();
      end
   end

   // ---------------------------------------------------------------------
   // response side ready, with random stalls and long hold-offs
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_gap     <= 0;
         rx_hold    <= 0;
      end else if (rx_hold_go) begin
         rsp_tready <= 1'b0;
         rx_hold    <= HOLD_CYCLES;
      end else if (rx_hold > 0) begin
         rsp_tready <= 1'b0;
         rx_hold    <= rx_hold - 1;
      end else if (rx_gap > 0) begin
         rsp_tready <= 1'b0;
         rx_gap     <= rx_gap - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!calm_stretch && $urandom_range(0, 3) == 0) rx_gap <= pick_gap();
      end
   end

   // ---------------------------------------------------------------------
   // monitor: predict on accepted words, check accepted responses
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_responses
      sem_result_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) semaphore_config(csr_index, csr_data);
         if (req_tvalid && req_tready) begin
            semaphore_step(cspwq_pkg::func_type'(req_tuser), req_tdata[3:0],
                           req_tdata[11:4], req_tdata[12], want);
            results_due.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               flag_mismatch("response word with nothing pending, status", rsp_tuser[2:0], 0);
            end else begin
               want = results_due.pop_front();
               if (rsp_tuser[2:0] != want.status)
                  flag_mismatch("status", rsp_tuser[2:0], want.status);
               if (rsp_tuser[3] != want.woken_valid)
                  flag_mismatch("woken_valid", rsp_tuser[3], want.woken_valid);
               if (rsp_tdata[3:0] != want.woken_task)
                  flag_mismatch("woken_task", rsp_tdata[3:0], want.woken_task);
               if (rsp_tdata[19:4] != want.count_now)
                  flag_mismatch("count_now", rsp_tdata[19:4], want.count_now);
            end
         end
         outstanding <= results_due.size();
      end
   end

   // ---------------------------------------------------------------------
   // run limit
   // ---------------------------------------------------------------------
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------
   // stimulus plan, reset and end of run
   // ---------------------------------------------------------------------
   initial begin : plan
      int items;
      int r;
      int len;
      kernel_call_type c;

      items = 0;
      c = '0;

      // directed: count edges, ordering, duplicates, cancel, unused code
      c.kind = CALL_REQ;
      c.func = cspwq_pkg::FUNC_GIVE;   call_queue.push_back(c);
      c.func = cspwq_pkg::FUNC_GIVE;   call_queue.push_back(c);
      c.func = cspwq_pkg::FUNC_TAKE; c.id = 4'd0;  c.prio = 8'd0;   c.may_wait = 1'b0;
      call_queue.push_back(c);
      c.func = cspwq_pkg::FUNC_TAKE; c.id = 4'd15; c.prio = 8'd255; c.may_wait = 1'b0;
      call_queue.push_back(c);
      c.may_wait = 1'b1;
      c.id = 4'd5;  c.prio = 8'd200; call_queue.push_back(c);
      c.id = 4'd3;  c.prio = 8'd10;  call_queue.push_back(c);
      c.id = 4'd9;  c.prio = 8'd10;  call_queue.push_back(c);
      c.id = 4'd5;  c.prio = 8'd0;   call_queue.push_back(c);
      c.id = 4'd15; c.prio = 8'd255; call_queue.push_back(c);
      c.func = cspwq_pkg::FUNC_CANCEL; c.id = 4'd5;  call_queue.push_back(c);
      c.func = cspwq_pkg::FUNC_CANCEL; c.id = 4'd12; call_queue.push_back(c);
      c.func = cspwq_pkg::FUNC_NONE;   c.id = 4'd15; call_queue.push_back(c);
      c.func = cspwq_pkg::FUNC_GIVE;
      repeat (5) call_queue.push_back(c);
      items = 17;

      // zero count limit reads as one; unknown indexes are ignored
      c = '0;
      c.kind = CALL_REG;
      c.reg_index = cspwq_pkg::REG_COUNT_LIMIT;   c.reg_value = 16'd0;    call_queue.push_back(c);
      c.reg_index = cspwq_pkg::REG_INITIAL_COUNT; c.reg_value = 16'hFFFF; call_queue.push_back(c);
      c.reg_index = cspwq_pkg::CSR_IDX_W'(2);     c.reg_value = 16'd7;    call_queue.push_back(c);
      c.reg_index = cspwq_pkg::CSR_IDX_W'(255);   c.reg_value = 16'h1234; call_queue.push_back(c);
      c.kind = CALL_REQ; c.func = cspwq_pkg::FUNC_GIVE; call_queue.push_back(c);
      c.kind = CALL_REG;
      c.reg_index = cspwq_pkg::REG_COUNT_LIMIT;   c.reg_value = 16'hFFFF; call_queue.push_back(c);
      c.reg_index = cspwq_pkg::REG_INITIAL_COUNT; c.reg_value = 16'hFFFF; call_queue.push_back(c);
      c.kind = CALL_REQ;
      c.func = cspwq_pkg::FUNC_GIVE;   call_queue.push_back(c);
      c.func = cspwq_pkg::FUNC_TAKE;   call_queue.push_back(c);
      c.func = cspwq_pkg::FUNC_CANCEL; c.id = 4'd0; call_queue.push_back(c);
      items += 4;

      // fill the wait list past its depth, then drain it with the receiver held
      c = '0;
      c.kind = CALL_REG; c.reg_index = cspwq_pkg::REG_INITIAL_COUNT; c.reg_value = 16'd0;
      call_queue.push_back(c);
      c.kind = CALL_REQ; c.func = cspwq_pkg::FUNC_TAKE; c.may_wait = 1'b1;
      repeat (cspwq_pkg::MAX_TASKS + 2) begin
         c.id   = cspwq_pkg::ID_W'($urandom_range(0, 15));
         c.prio = cspwq_pkg::PRIO_W'($urandom_range(0, 3));
         call_queue.push_back(c);
         items++;
      end
      c.kind = CALL_HOLD; call_queue.push_back(c);
      c.kind = CALL_REQ;  c.func = cspwq_pkg::FUNC_GIVE;
      repeat (cspwq_pkg::MAX_TASKS + 4) begin
         call_queue.push_back(c);
         items++;
      end
      c.kind = CALL_DRAIN; call_queue.push_back(c);

      // random episodes
      while (items < TOTAL_CALLS) begin
         r = $urandom_range(0, 99);
         c = '0;
         if (r < 15) begin
            // new settings, extremes weighted in
            c.kind = CALL_REG;
            c.reg_index = cspwq_pkg::REG_COUNT_LIMIT;
            r = $urandom_range(0, 99);
            c.reg_value = (r < 15) ? 16'd0 : (r < 30) ? 16'd1 :
                          (r < 60) ? 16'($urandom_range(2, 5)) :
                          (r < 80) ? 16'($urandom) : 16'hFFFF;
            call_queue.push_back(c);
            c.reg_index = cspwq_pkg::REG_INITIAL_COUNT;
            r = $urandom_range(0, 99);
            c.reg_value = (r < 40) ? 16'd0 : (r < 60) ? 16'($urandom_range(1, 3)) :
                          (r < 80) ? 16'($urandom) : 16'hFFFF;
            call_queue.push_back(c);
            if ($urandom_range(0, 4) == 0) begin
               c.reg_index = cspwq_pkg::CSR_IDX_W'($urandom_range(2, 255));
               c.reg_value = 16'($urandom);
               call_queue.push_back(c);
            end
         end else begin
            len = $urandom_range(8, 30);
            c.kind = CALL_REQ;
            repeat (len) begin
               c.id       = cspwq_pkg::ID_W'($urandom_range(0, 15));
               c.prio     = $urandom_range(0, 1) ?
                            cspwq_pkg::PRIO_W'($urandom_range(0, 3)) :
                            cspwq_pkg::PRIO_W'($urandom_range(0, 255));
               c.may_wait = ($urandom_range(0, 99) < 85);
               if (r < 30) begin
                  c.func = cspwq_pkg::FUNC_TAKE;
               end else if (r < 45) begin
                  c.func = cspwq_pkg::FUNC_GIVE;
               end else begin
                  len = $urandom_range(0, 99);
                  c.func = (len < 40) ? cspwq_pkg::FUNC_TAKE :
                           (len < 75) ? cspwq_pkg::FUNC_GIVE :
                           (len < 95) ? cspwq_pkg::FUNC_CANCEL : cspwq_pkg::FUNC_NONE;
               end
               call_queue.push_back(c);
               items++;
            end
         end
         r = $urandom_range(0, 99);
         if (r < 5) begin
            c.kind = CALL_HOLD;  call_queue.push_back(c);
         end else if (r < 10) begin
            c.kind = CALL_DRAIN; call_queue.push_back(c);
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // wait for every call to be sent and every response to come back
      do @(posedge clock);
      while (calls_left != 0 || req_tvalid || csr_valid || outstanding != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (outstanding != 0) flag_mismatch("responses still pending", outstanding, 0);

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
